[rtl/versioned_stack_undo_redo_unit_assert.svh]
// assertion macros shared by the versioned stack rtl
// no dependencies; included by the modules that check their own logic
`ifndef VERSIONED_STACK_UNDO_REDO_UNIT_ASSERT_SVH
`define VERSIONED_STACK_UNDO_REDO_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define VSUR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vsur assertion failed");
// antecedent implies consequent in the next cycle
`define VSUR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vsur assertion failed");
`else
`define VSUR_ASSERT_NOW(label, clk, rst, ante, cons)
`define VSUR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/vsur_pkg.sv]
// types and constants of the versioned stack with undo and redo
// no dependencies; used by the interfaces, the node store and the top level
package vsur_pkg;

  localparam int NODE_SLOTS   = 65536;
  localparam int HANDLE_SLOTS = 4096;

  localparam int NODE_AW   = $clog2(NODE_SLOTS);
  localparam int NODE_CW   = $clog2(NODE_SLOTS + 1);
  localparam int HANDLE_AW = 12;
  localparam int HANDLE_CW = HANDLE_AW + 1;
  localparam int VAL_W     = 30;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 3;

  // node index of the null link and of the shared basic node
  localparam logic [NODE_AW-1:0] NODE_NULL = '0;
  localparam logic [NODE_AW-1:0] NODE_BASE = NODE_AW'(1);
  localparam logic [HANDLE_AW-1:0] HANDLE_FIRST = HANDLE_AW'(1);

  typedef enum logic [OP_W-1:0] {
    OP_LEARN    = 3'd0,
    OP_ROLLBACK = 3'd1,
    OP_RELEARN  = 3'd2,
    OP_CLONE    = 3'd3,
    OP_CHECK    = 3'd4
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_HISTORY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_REDO    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd5;

  typedef struct packed {
    logic [VAL_W-1:0]   val;
    logic               basic;
    logic [NODE_AW-1:0] back;
    logic [NODE_AW-1:0] redo;
  } node_t;

  localparam node_t BASE_NODE = '{val: '0, basic: 1'b1, back: '0, redo: '0};

endpackage

[rtl/vsur_req_if.sv]
// request channel of the versioned stack: valid/ready plus one operation
// depends on vsur_pkg
interface vsur_req_if;
  logic                            valid;
  logic                            ready;
  logic [vsur_pkg::OP_W-1:0]       operation;
  logic [vsur_pkg::HANDLE_AW-1:0]  handle_index;
  logic [vsur_pkg::VAL_W-1:0]      program_value;

  modport source (output valid, operation, handle_index, program_value, input ready);
  modport sink (input valid, operation, handle_index, program_value, output ready);
endinterface

// response channel of the versioned stack: valid/ready plus one result
interface vsur_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [vsur_pkg::STATUS_W-1:0]   status;
  logic [vsur_pkg::VAL_W-1:0]      top_value;
  logic                            is_basic;
  logic [vsur_pkg::HANDLE_AW-1:0]  new_handle;

  modport source (output valid, status, top_value, is_basic, new_handle, input ready);
  modport sink (input valid, status, top_value, is_basic, new_handle, output ready);
endinterface

[rtl/versioned_stack_undo_redo_unit.sv]
// top level of the versioned stack with undo and redo
// depends on vsur_pkg, vsur_req_if, vsur_rsp_if, vsur_node_store, assertion header
//
// usage
//   req carries one operation (learn, rollback, relearn, clone, check) on a
//   handle; rsp returns exactly one result per request transfer, in order.
//   every result carries a status; top_value/is_basic only for a good check,
//   new_handle only for a good clone, zero otherwise.
// sequence
//   learn, rollback and relearn pass through these steps: accept plus
//   handle table read, node read of the current top, node read of the back or
//   redo target for rollback and relearn, node and handle write, then the
//   result is loaded. check, clone and refused ops skip the write; a bad
//   handle also skips the node reads. the single node pool read port sets the
//   two dependent node reads in a row. a new request is taken only after the
//   last result is loaded, and loading waits while rsp holds an untaken result.
// reset
//   rst (synchronous) gives handle 1 on the basic node; next free node is 2
//   and next free handle 2. no clearing pass: unused entries are never read.
// stall
//   the result sits in an output register; a new request is taken while it
//   waits, but the next result holds in the sequencer until rsp drains.
`include "versioned_stack_undo_redo_unit_assert.svh"

module versioned_stack_undo_redo_unit (
  input  logic       clk,
  input  logic       rst,
  vsur_req_if.sink   req,
  vsur_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR,
    S_LINK,
    S_WRITE,
    S_DONE
  } state_t;

  state_t state;

  // latched request
  vsur_pkg::op_t                   op;
  logic [vsur_pkg::HANDLE_AW-1:0]  h;
  logic [vsur_pkg::VAL_W-1:0]      pv;
  logic                            bad;

  // working registers
  logic [vsur_pkg::NODE_AW-1:0]    cur;
  logic [vsur_pkg::STATUS_W-1:0]   status;
  logic [vsur_pkg::VAL_W-1:0]      top;
  logic                            basic;
  logic [vsur_pkg::HANDLE_AW-1:0]  newh;

  // allocation counters
  logic [vsur_pkg::NODE_CW-1:0]    nfn;
  logic [vsur_pkg::HANDLE_CW-1:0]  nfh;
  logic                            h1_written;

  // handle table
  logic [vsur_pkg::NODE_AW-1:0]    ht_mem [vsur_pkg::HANDLE_SLOTS];
  logic [vsur_pkg::NODE_AW-1:0]    ht_q;
  logic                            ht_we;
  logic [vsur_pkg::HANDLE_AW-1:0]  ht_waddr;
  logic [vsur_pkg::NODE_AW-1:0]    ht_wdata;
  logic [vsur_pkg::NODE_AW-1:0]    ht_cur;

  // node pool port
  logic                            ns_we;
  vsur_pkg::node_t                 ns_wdata;
  logic                            ns_re;
  logic [vsur_pkg::NODE_AW-1:0]    ns_raddr;
  vsur_pkg::node_t                 ns_rdata;

  logic req_xfer;
  logic out_free;
  logic pool_full;
  logic table_full;
  logic bad_in;

  // result channel views for the checks below
  logic                            rsp_stall;
  logic                            rsp_clean;
  logic [vsur_pkg::STATUS_W+vsur_pkg::VAL_W+vsur_pkg::HANDLE_AW:0] rsp_word;

  assign req.ready  = (state == S_IDLE);
  assign req_xfer   = req.valid && req.ready;
  assign out_free   = !rsp.valid || rsp.ready;
  assign pool_full  = (nfn == vsur_pkg::NODE_CW'(vsur_pkg::NODE_SLOTS));
  assign table_full = (nfh == vsur_pkg::HANDLE_CW'(vsur_pkg::HANDLE_SLOTS));
  assign bad_in     = (req.handle_index == '0) || ({1'b0, req.handle_index} >= nfh);

  assign rsp_stall = rsp.valid && !rsp.ready;
  assign rsp_clean = (rsp.top_value == '0) && !rsp.is_basic && (rsp.new_handle == '0);
  assign rsp_word  = {rsp.status, rsp.top_value, rsp.is_basic, rsp.new_handle};

  // handle 1 reads as the basic node until it is first written
  assign ht_cur = ((h == vsur_pkg::HANDLE_FIRST) && !h1_written) ? vsur_pkg::NODE_BASE : ht_q;

  // handle table write: new top after a node write, or the shared node on clone
  always_comb begin
    ht_we    = 1'b0;
    ht_waddr = h;
    ht_wdata = nfn[vsur_pkg::NODE_AW-1:0];
    if (state == S_WRITE) begin
      ht_we = 1'b1;
    end else if ((state == S_LINK) && (op == vsur_pkg::OP_CLONE) && !table_full) begin
      ht_we    = 1'b1;
      ht_waddr = nfh[vsur_pkg::HANDLE_AW-1:0];
      ht_wdata = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (ht_we) begin
      ht_mem[ht_waddr] <= ht_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      ht_q <= ht_mem[req.handle_index];
    end
  end

  // node reads: the current top, then the back or redo target
  always_comb begin
    ns_re    = 1'b0;
    ns_raddr = ht_cur;
    if ((state == S_CUR) && !bad) begin
      ns_re = 1'b1;
    end else if ((state == S_LINK) && !pool_full) begin
      if ((op == vsur_pkg::OP_ROLLBACK) && (ns_rdata.back != vsur_pkg::NODE_NULL)) begin
        ns_re    = 1'b1;
        ns_raddr = ns_rdata.back;
      end else if ((op == vsur_pkg::OP_RELEARN) && (ns_rdata.redo != vsur_pkg::NODE_NULL)) begin
        ns_re    = 1'b1;
        ns_raddr = ns_rdata.redo;
      end
    end
  end

  // new node built from the pushed value or the fetched target
  always_comb begin
    ns_we    = (state == S_WRITE);
    ns_wdata = '{val: pv, basic: 1'b0, back: cur, redo: vsur_pkg::NODE_NULL};
    case (op)
      vsur_pkg::OP_ROLLBACK: begin
        ns_wdata = '{val: ns_rdata.val, basic: ns_rdata.basic,
                     back: ns_rdata.back, redo: cur};
      end
      vsur_pkg::OP_RELEARN: begin
        ns_wdata = '{val: ns_rdata.val, basic: ns_rdata.basic,
                     back: cur, redo: ns_rdata.redo};
      end
      default: begin
        ns_wdata = '{val: pv, basic: 1'b0, back: cur, redo: vsur_pkg::NODE_NULL};
      end
    endcase
  end

  vsur_node_store u_nodes (
    .clk   (clk),
    .rst   (rst),
    .we    (ns_we),
    .waddr (nfn[vsur_pkg::NODE_AW-1:0]),
    .wdata (ns_wdata),
    .re    (ns_re),
    .raddr (ns_raddr),
    .rdata (ns_rdata)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nfn        <= vsur_pkg::NODE_CW'(2);
      nfh        <= vsur_pkg::HANDLE_CW'(2);
      h1_written <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      // a transfer frees the register unless a new result is loaded now
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      if (ht_we && (ht_waddr == vsur_pkg::HANDLE_FIRST)) begin
        h1_written <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            op     <= vsur_pkg::op_t'(req.operation);
            h      <= req.handle_index;
            pv     <= req.program_value;
            bad    <= bad_in;
            status <= bad_in ? vsur_pkg::ST_BAD_HANDLE : vsur_pkg::ST_OK;
            top    <= '0;
            basic  <= 1'b0;
            newh   <= '0;
            state  <= S_CUR;
          end
        end
        S_CUR: begin
          cur   <= ht_cur;
          state <= bad ? S_DONE : S_LINK;
        end
        S_LINK: begin
          state <= S_DONE;
          case (op)
            vsur_pkg::OP_LEARN: begin
              if (pool_full) begin
                status <= vsur_pkg::ST_POOL_FULL;
              end else begin
                state <= S_WRITE;
              end
            end
            vsur_pkg::OP_ROLLBACK: begin
              if (ns_rdata.back == vsur_pkg::NODE_NULL) begin
                status <= vsur_pkg::ST_NO_HISTORY;
              end else if (pool_full) begin
                status <= vsur_pkg::ST_POOL_FULL;
              end else begin
                state <= S_WRITE;
              end
            end
            vsur_pkg::OP_RELEARN: begin
              if (ns_rdata.redo == vsur_pkg::NODE_NULL) begin
                status <= vsur_pkg::ST_NO_REDO;
              end else if (pool_full) begin
                status <= vsur_pkg::ST_POOL_FULL;
              end else begin
                state <= S_WRITE;
              end
            end
            vsur_pkg::OP_CLONE: begin
              if (table_full) begin
                status <= vsur_pkg::ST_TABLE_FULL;
              end else begin
                newh <= nfh[vsur_pkg::HANDLE_AW-1:0];
                nfh  <= nfh + vsur_pkg::HANDLE_CW'(1);
              end
            end
            default: begin
              // check, and unused codes behave as check
              basic <= ns_rdata.basic;
              top   <= ns_rdata.basic ? '0 : ns_rdata.val;
            end
          endcase
        end
        S_WRITE: begin
          nfn   <= nfn + vsur_pkg::NODE_CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp.valid      <= 1'b1;
            rsp.status     <= status;
            rsp.top_value  <= top;
            rsp.is_basic   <= basic;
            rsp.new_handle <= newh;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // node pool grows by one exactly on a node write, never past its size
  `VSUR_ASSERT_NEXT(a_nfn_step, clk, rst, ns_we, nfn == $past(nfn) + vsur_pkg::NODE_CW'(1))
  `VSUR_ASSERT_NOW(a_write_room, clk, rst, ns_we, !pool_full)
  // failed operations report no data
  `VSUR_ASSERT_NOW(a_fail_clean, clk, rst, rsp.valid && (rsp.status != vsur_pkg::ST_OK), rsp_clean)
  // a stalled result stays put until it is taken
  `VSUR_ASSERT_NEXT(a_no_overrun, clk, rst, rsp_stall, rsp.valid && $stable(rsp_word))
  `VSUR_ASSERT_NEXT(a_hold_done, clk, rst, (state == S_DONE) && rsp_stall, state == S_DONE)

endmodule

[rtl/vsur_node_store.sv]
// node pool memory: one write port, one registered read port
// depends on vsur_pkg and the assertion header; node 1 reads as the basic node
`include "versioned_stack_undo_redo_unit_assert.svh"

module vsur_node_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [vsur_pkg::NODE_AW-1:0]  waddr,
  input  vsur_pkg::node_t               wdata,
  input  logic                          re,
  input  logic [vsur_pkg::NODE_AW-1:0]  raddr,
  output vsur_pkg::node_t               rdata
);

  vsur_pkg::node_t mem [vsur_pkg::NODE_SLOTS];
  vsur_pkg::node_t q;
  logic            q_base;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q      <= mem[raddr];
      q_base <= (raddr == vsur_pkg::NODE_BASE);
    end
  end

  // node 1 is never written, so it is served from a constant
  assign rdata = q_base ? vsur_pkg::BASE_NODE : q;

  `VSUR_ASSERT_NOW(a_no_write_low, clk, rst, we, waddr > vsur_pkg::NODE_BASE)
  `VSUR_ASSERT_NOW(a_no_null_read, clk, rst, re, raddr != vsur_pkg::NODE_NULL)
  `VSUR_ASSERT_NOW(a_no_rw_same, clk, rst, we && re, waddr != raddr)

endmodule
